// ===== sv/ifrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_pkg
// Shared types and constants of the IPv6 fragment reassembly tracker.
// ----------------------------------------------------------------------------
package ifrt_pkg;

  localparam int LEN_W = 17;

  localparam logic [15:0] OFFSET_MASK   = 16'hFFF8;
  localparam logic [15:0] MF_BIT_MASK   = 16'h0001;
  localparam logic [63:0] TIMEOUT_RESET = 64'd60000000000;

  typedef enum logic [1:0] {
    ACT_FRAG  = 2'd0,
    ACT_SWEEP = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_SWEPT    = 3'd3,
    ST_FLUSHED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [31:0] ident;
    logic [7:0]  proto;
  } key_t;

  // Result of one merge run, handed back to the tracker.
  typedef struct packed {
    logic             done;
    logic             upd;
    logic [LEN_W-1:0] first_lo;
    logic [LEN_W-1:0] first_hi;
  } mrg_rsp_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SRCH_RD,
    T_SRCH_CMP,
    T_ALLOC,
    T_MERGE,
    T_WAIT,
    T_SWP_RD,
    T_SWP_CMP
  } top_state_e;

  typedef enum logic [3:0] {
    M_IDLE,
    M_RD,
    M_PUSH,
    M_TAIL,
    M_FLUSH,
    M_CP_RD,
    M_CP_WR,
    M_CHK_RD,
    M_CHK
  } mrg_state_e;

endpackage

// ===== sv/ifrt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_in_if
// Request channel: one fragment, sweep or flush per transaction.
// ----------------------------------------------------------------------------
interface ifrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;
  logic [63:0] dst_addr_high;
  logic [63:0] dst_addr_low;
  logic [31:0] fragment_ident;
  logic [7:0]  next_header;
  logic [15:0] offset_field;
  logic [15:0] fragment_length;
  logic [63:0] now_time;

  modport source (output valid, action, src_addr_high, src_addr_low, dst_addr_high,
                  dst_addr_low, fragment_ident, next_header, offset_field,
                  fragment_length, now_time, input ready);
  modport sink (input valid, action, src_addr_high, src_addr_low, dst_addr_high,
                dst_addr_low, fragment_ident, next_header, offset_field,
                fragment_length, now_time, output ready);
endinterface

// ===== sv/ifrt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_out_if
// Result channel: one status transaction per request.
// ----------------------------------------------------------------------------
interface ifrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [16:0] total_length;
  logic [7:0]  expired_count;

  modport source (output valid, status, total_length, expired_count, input ready);
  modport sink (input valid, status, total_length, expired_count, output ready);
endinterface

// ===== sv/ifrt_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_cfg_if
// Configuration write channel for the idle timeout register.
// ----------------------------------------------------------------------------
interface ifrt_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/ifrt_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_merge
// Interval store and sequential sorted-merge unit; a new run starts only once the last one is done.
// ----------------------------------------------------------------------------
module ifrt_merge
  import ifrt_pkg::*;
#(
  parameter int CONTEXTS  = 32,
  parameter int INTERVALS = 32,
  localparam int CXW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1,
  localparam int NW  = $clog2(INTERVALS + 1),
  localparam int CW  = $clog2(INTERVALS + 2),
  localparam int AW  = (CONTEXTS * INTERVALS > 1) ? $clog2(CONTEXTS * INTERVALS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CXW-1:0]   ctx_i,
  input  logic [LEN_W-1:0] lo_i,
  input  logic [LEN_W-1:0] hi_i,
  input  logic [NW-1:0]    cnt_i,
  output mrg_rsp_t         rsp_o,
  output logic [NW-1:0]    cnt_o
);

  mrg_state_e state_q, state_d;

  logic [LEN_W-1:0] iv_lo_mem [CONTEXTS*INTERVALS];
  logic [LEN_W-1:0] iv_hi_mem [CONTEXTS*INTERVALS];
  logic [LEN_W-1:0] sc_lo_mem [INTERVALS+1];
  logic [LEN_W-1:0] sc_hi_mem [INTERVALS+1];

  logic [CXW-1:0]   ctx_q;
  logic [LEN_W-1:0] lo_q, hi_q, top_lo_q, top_hi_q, top_lo_d, top_hi_d;
  logic [LEN_W-1:0] iv_lo_rd_q, iv_hi_rd_q, sc_lo_rd_q, sc_hi_rd_q;
  logic [LEN_W-1:0] first_lo_q, first_hi_q;
  logic [NW-1:0]    cnt_q, i_q, k_q;
  logic [CW-1:0]    n_q, n_d;
  logic             placed_q, upd_q, done_q;

  logic [AW-1:0]    base, iv_ra, iv_wa;
  logic             iv_we;
  logic [NW-1:0]    sc_wa, sc_ra;
  logic             sc_we;
  logic [LEN_W-1:0] sc_wlo, sc_whi;
  logic             push_en;
  logic [LEN_W-1:0] push_lo, push_hi;
  logic             take_new;

  assign base     = AW'(ctx_q) * AW'(INTERVALS);
  assign take_new = !placed_q && (lo_q < iv_lo_rd_q);

  // Push one interval onto the merge list; the open top entry stays in flops.
  always_comb begin
    push_en  = 1'b0;
    push_lo  = lo_q;
    push_hi  = hi_q;
    unique case (state_q)
      M_PUSH: begin
        push_en = 1'b1;
        if (!take_new) begin
          push_lo = iv_lo_rd_q;
          push_hi = iv_hi_rd_q;
        end
      end
      M_TAIL:  push_en = !placed_q;
      default: push_en = 1'b0;
    endcase
  end

  always_comb begin
    top_lo_d = top_lo_q;
    top_hi_d = top_hi_q;
    n_d      = n_q;
    sc_we    = 1'b0;
    sc_wa    = NW'(n_q - CW'(1));
    sc_wlo   = top_lo_q;
    sc_whi   = top_hi_q;
    if (push_en) begin
      if (n_q != '0 && top_hi_q >= push_lo) begin
        if (push_hi > top_hi_q) top_hi_d = push_hi;
      end else if (n_q <= CW'(INTERVALS)) begin
        sc_we    = (n_q != '0);
        top_lo_d = push_lo;
        top_hi_d = push_hi;
        n_d      = n_q + CW'(1);
      end
    end
    if (state_q == M_FLUSH && n_q <= CW'(INTERVALS)) sc_we = 1'b1;
  end

  always_comb begin
    iv_ra = base + AW'(i_q);
    iv_wa = base + AW'(k_q);
    iv_we = (state_q == M_CP_WR);
    sc_ra = k_q;
    if (state_q == M_CHK_RD) iv_ra = base;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: begin
        if (start_i) begin
          if (lo_i >= hi_i)       state_d = M_CHK_RD;
          else if (cnt_i == '0)   state_d = M_TAIL;
          else                    state_d = M_RD;
        end
      end
      M_RD:   state_d = M_PUSH;
      M_PUSH: begin
        if (!take_new) begin
          state_d = ((CW'(i_q) + CW'(1)) == CW'(cnt_q)) ? M_TAIL : M_RD;
        end
      end
      M_TAIL:  state_d = M_FLUSH;
      M_FLUSH: state_d = (n_q > CW'(INTERVALS)) ? M_CHK_RD : M_CP_RD;
      M_CP_RD: state_d = M_CP_WR;
      M_CP_WR: state_d = ((CW'(k_q) + CW'(1)) == n_q) ? M_CHK_RD : M_CP_RD;
      M_CHK_RD: state_d = M_CHK;
      M_CHK:    state_d = M_IDLE;
      default:  state_d = M_IDLE;
    endcase
  end

  // Hold done and the first interval until the next run starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == M_IDLE && start_i) begin
        upd_q  <= 1'b0;
        done_q <= 1'b0;
      end
      if (state_q == M_CHK) done_q <= 1'b1;
      if (state_q == M_CP_WR && state_d == M_CHK_RD) upd_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      ctx_q    <= ctx_i;
      lo_q     <= lo_i;
      hi_q     <= hi_i;
      cnt_q    <= cnt_i;
      i_q      <= '0;
      k_q      <= '0;
      n_q      <= '0;
      placed_q <= 1'b0;
    end else begin
      n_q      <= n_d;
      top_lo_q <= top_lo_d;
      top_hi_q <= top_hi_d;
      if (state_q == M_PUSH) begin
        if (take_new) placed_q <= 1'b1;
        else          i_q      <= i_q + NW'(1);
      end
      if (state_q == M_TAIL) placed_q <= 1'b1;
      if (state_q == M_CP_WR) k_q <= k_q + NW'(1);
    end
    if (state_q == M_CHK) begin
      first_lo_q <= iv_lo_rd_q;
      first_hi_q <= iv_hi_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    iv_lo_rd_q <= iv_lo_mem[iv_ra];
    iv_hi_rd_q <= iv_hi_mem[iv_ra];
    if (iv_we) begin
      iv_lo_mem[iv_wa] <= sc_lo_rd_q;
      iv_hi_mem[iv_wa] <= sc_hi_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_lo_rd_q <= sc_lo_mem[sc_ra];
    sc_hi_rd_q <= sc_hi_mem[sc_ra];
    if (sc_we) begin
      sc_lo_mem[sc_wa] <= sc_wlo;
      sc_hi_mem[sc_wa] <= sc_whi;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.upd      = upd_q;
  assign rsp_o.first_lo = first_lo_q;
  assign rsp_o.first_hi = first_hi_q;
  assign cnt_o          = NW'(n_q);

endmodule

// ===== sv/ipv6_fragment_reassembly_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_fragment_reassembly_tracker
// Tracks IPv6 fragment coverage per reassembly context and reports completion.
// ----------------------------------------------------------------------------
// Channels: in_i takes one request per transaction (fragment, sweep, flush);
// out_o returns exactly one status transaction per request, in order; cfg_i
// writes the 64-bit idle timeout and is always ready.
// A request is taken only while the tracker is idle and the output register
// is empty or being read in the same cycle; in_i.ready drops for the whole
// of its processing.
// Steps: a fragment walks the context table, reading and then comparing
// each context; the merge unit then reads each entry of the interval list,
// pushes it and the new interval into the merged list in sorted order, and
// copies the merged list back entry by entry, reading then writing; the
// context search and the interval memory port set the time a fragment takes.
// A sweep walks every context and presents its result at the end; a flush or
// a reserved action presents it in the cycle right after acceptance.
// The result sits in an output register; while the receiver stalls, a
// finished result waits in the sequencer and the input stays closed.
// Reset clears all context valid flags, lengths and counts and loads the
// default idle timeout; key, time stamp and interval memories are not cleared.
// ----------------------------------------------------------------------------
module ipv6_fragment_reassembly_tracker
  import ifrt_pkg::*;
#(
  parameter int CONTEXTS  = 32,
  parameter int INTERVALS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ifrt_in_if.sink     in_i,
  ifrt_out_if.source  out_o,
  ifrt_cfg_if.sink    cfg_i
);

  localparam int CXW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int NW  = $clog2(INTERVALS + 1);

  top_state_e state_q, state_d;

  // Context table: keys and time stamps in memories, control in flops.
  key_t             key_mem [CONTEXTS];
  logic [63:0]      ls_mem  [CONTEXTS];
  key_t             key_rd_q;
  logic [63:0]      ls_rd_q;
  logic [CONTEXTS-1:0] valid_q, saw_q;
  logic [LEN_W-1:0] tot_q [CONTEXTS];
  logic [NW-1:0]    ivc_q [CONTEXTS];

  logic [63:0]      timeout_q;

  // Latched request
  key_t             key_q;
  logic [LEN_W-1:0] lo_q, hi_q;
  logic             more_q;
  logic [63:0]      now_q;

  logic [CXW-1:0]   c_q, hit_q, free_q;
  logic             free_seen_q;
  logic [7:0]       exp_q;

  // Output register
  logic             ov_q;
  status_e          ost_q;
  logic [LEN_W-1:0] otot_q;
  logic [7:0]       oexp_q;

  logic             accept, last_c, key_hit, idle_hit, complete, slot_free, respond;
  logic [63:0]      age;
  logic [NW-1:0]    new_cnt;
  status_e          rst_st;
  logic [LEN_W-1:0] rtot;
  logic [7:0]       rexp;
  logic             mrg_start;
  mrg_rsp_t         mrg_rsp;
  logic [NW-1:0]    mrg_cnt;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == T_IDLE) && slot_free;
  assign cfg_i.ready = 1'b1;
  assign slot_free = !ov_q || out_o.ready;
  assign last_c    = (c_q == CXW'(CONTEXTS - 1));
  assign key_hit   = valid_q[c_q] && (key_rd_q == key_q);
  assign age       = now_q - ls_rd_q;
  assign idle_hit  = valid_q[c_q] && (age > timeout_q);
  assign new_cnt   = mrg_rsp.upd ? mrg_cnt : ivc_q[hit_q];
  assign complete  = saw_q[hit_q] && (new_cnt != '0) && (mrg_rsp.first_lo == '0) &&
                     (mrg_rsp.first_hi >= tot_q[hit_q]);
  assign mrg_start = (state_q == T_MERGE);

  ifrt_merge #(
    .CONTEXTS  (CONTEXTS),
    .INTERVALS (INTERVALS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mrg_start),
    .ctx_i   (hit_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .cnt_i   (ivc_q[hit_q]),
    .rsp_o   (mrg_rsp),
    .cnt_o   (mrg_cnt)
  );

  // Sequencer: decide the next step and when a result is produced.
  always_comb begin
    state_d = state_q;
    respond = 1'b0;
    rst_st  = ST_PENDING;
    rtot    = '0;
    rexp    = '0;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          unique case (action_e'(in_i.action))
            ACT_FRAG:  state_d = T_SRCH_RD;
            ACT_SWEEP: state_d = T_SWP_RD;
            ACT_FLUSH: begin
              respond = 1'b1;
              rst_st  = ST_FLUSHED;
            end
            default:   respond = 1'b1;
          endcase
        end
      end
      T_SRCH_RD: state_d = T_SRCH_CMP;
      T_SRCH_CMP: begin
        if (key_hit) begin
          state_d = T_MERGE;
        end else if (last_c) begin
          if (free_seen_q || !valid_q[c_q]) begin
            state_d = T_ALLOC;
          end else begin
            respond = 1'b1;
            rst_st  = ST_DROPPED;
          end
        end else begin
          state_d = T_SRCH_RD;
        end
      end
      T_ALLOC: state_d = T_MERGE;
      T_MERGE: state_d = T_WAIT;
      T_WAIT: begin
        if (mrg_rsp.done) begin
          respond = 1'b1;
          if (complete) begin
            rst_st = ST_COMPLETE;
            rtot   = tot_q[hit_q];
          end
        end
      end
      T_SWP_RD: state_d = T_SWP_CMP;
      T_SWP_CMP: begin
        if (last_c) begin
          respond = 1'b1;
          rst_st  = ST_SWEPT;
          rexp    = exp_q + {7'd0, idle_hit};
        end else begin
          state_d = T_SWP_RD;
        end
      end
      default: state_d = T_IDLE;
    endcase
    // Hold the finished result until the output register is free.
    if (respond) state_d = slot_free ? T_IDLE : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      timeout_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (respond && slot_free) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (respond && slot_free) begin
      ost_q  <= rst_st;
      otot_q <= rtot;
      oexp_q <= rexp;
    end
  end

  // Context control flops; free a context by clearing all four together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      saw_q   <= '0;
      for (int c = 0; c < CONTEXTS; c++) begin
        tot_q[c] <= '0;
        ivc_q[c] <= '0;
      end
    end else begin
      unique case (state_q)
        T_IDLE: begin
          if (accept && action_e'(in_i.action) == ACT_FLUSH) begin
            valid_q <= '0;
            saw_q   <= '0;
            for (int c = 0; c < CONTEXTS; c++) begin
              tot_q[c] <= '0;
              ivc_q[c] <= '0;
            end
          end
        end
        T_ALLOC: begin
          valid_q[hit_q] <= 1'b1;
          saw_q[hit_q]   <= 1'b0;
          tot_q[hit_q]   <= '0;
          ivc_q[hit_q]   <= '0;
        end
        T_MERGE: begin
          if (!more_q) begin
            saw_q[hit_q] <= 1'b1;
            if (tot_q[hit_q] < hi_q) tot_q[hit_q] <= hi_q;
          end
        end
        T_WAIT: begin
          if (mrg_rsp.done && slot_free) begin
            if (complete) begin
              valid_q[hit_q] <= 1'b0;
              saw_q[hit_q]   <= 1'b0;
              tot_q[hit_q]   <= '0;
              ivc_q[hit_q]   <= '0;
            end else begin
              ivc_q[hit_q]   <= new_cnt;
            end
          end
        end
        T_SWP_CMP: begin
          if (idle_hit && (slot_free || !last_c)) begin
            valid_q[c_q] <= 1'b0;
            saw_q[c_q]   <= 1'b0;
            tot_q[c_q]   <= '0;
            ivc_q[c_q]   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Request latch, walk counter and search bookkeeping.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q       <= '{in_i.src_addr_high, in_i.src_addr_low, in_i.dst_addr_high,
                       in_i.dst_addr_low, in_i.fragment_ident, in_i.next_header};
      lo_q        <= LEN_W'(in_i.offset_field & OFFSET_MASK);
      hi_q        <= LEN_W'(in_i.offset_field & OFFSET_MASK) + LEN_W'(in_i.fragment_length);
      more_q      <= (in_i.offset_field & MF_BIT_MASK) != '0;
      now_q       <= in_i.now_time;
      c_q         <= '0;
      free_seen_q <= 1'b0;
      exp_q       <= '0;
    end
    if (state_q == T_SRCH_CMP) begin
      if (key_hit) begin
        hit_q <= c_q;
      end else if (last_c) begin
        hit_q <= free_seen_q ? free_q : c_q;
      end else begin
        c_q <= c_q + CXW'(1);
        if (!valid_q[c_q] && !free_seen_q) begin
          free_q      <= c_q;
          free_seen_q <= 1'b1;
        end
      end
    end
    if (state_q == T_SWP_CMP && !last_c) begin
      c_q   <= c_q + CXW'(1);
      exp_q <= exp_q + {7'd0, idle_hit};
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[c_q];
    ls_rd_q  <= ls_mem[c_q];
    if (state_q == T_ALLOC) key_mem[hit_q] <= key_q;
    if (state_q == T_MERGE) ls_mem[hit_q] <= now_q;
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = ost_q;
  assign out_o.total_length  = otot_q;
  assign out_o.expired_count = oexp_q;

endmodule

// ===== sv/ifrt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_checker
// Port-level checks of the reassembly tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ifrt_checker
  import ifrt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [16:0] total_length_i,
  input logic [7:0]  expired_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while result stalled");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_COMPLETE |-> total_length_i == '0)
    else $error("length reported without completion");

  a_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_SWEPT |-> expired_count_i == '0)
    else $error("expired count outside a sweep");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_FLUSHED)
    else $error("status code out of range");

endmodule

bind ipv6_fragment_reassembly_tracker ifrt_checker u_ifrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .total_length_i  (out_o.total_length),
  .expired_count_i (out_o.expired_count)
);

// ===== tb/ifrt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_scoreboard
// Watches the request, result and configuration channels of the reassembly
// tracker, predicts each result from its own model of the context table and
// compares the results in order, field by field.
// ----------------------------------------------------------------------------
module ifrt_scoreboard
  import ifrt_pkg::*;
#(
  parameter int CONTEXTS  = 32,
  parameter int INTERVALS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ifrt_in_if.sink     in_i,
  ifrt_out_if.sink    out_i,
  ifrt_cfg_if.sink    cfg_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    status_e     status;
    logic [16:0] total;
    logic [7:0]  expired;
  } verdict_t;

  logic [63:0] timeout_q;
  logic        live     [CONTEXTS];
  key_t        keys     [CONTEXTS];
  logic [63:0] stamp    [CONTEXTS];
  logic        got_last [CONTEXTS];
  logic [16:0] tot_len  [CONTEXTS];
  int          span_cnt [CONTEXTS];
  logic [16:0] span_lo  [CONTEXTS][INTERVALS];
  logic [16:0] span_hi  [CONTEXTS][INTERVALS];
  verdict_t    awaited  [$];

  assign pending_o = awaited.size();

  function automatic void release_ctx(int c);
    live[c] = 1'b0;
    got_last[c] = 1'b0;
    tot_len[c] = '0;
    span_cnt[c] = 0;
  endfunction

  // Insert [s,e) into the sorted span list; give up if it would overflow.
  function automatic void merge_span(int c, logic [16:0] s, logic [16:0] e);
    logic [16:0] ms [INTERVALS+1];
    logic [16:0] me [INTERVALS+1];
    int n;
    bit placed;
    logic [16:0] a, b;
    n = 0;
    placed = 0;
    if (s >= e) return;
    for (int i = 0; i <= span_cnt[c]; i++) begin
      for (int k = 0; k < 2; k++) begin
        if (k == 0) begin
          if (placed || (i < span_cnt[c] && s >= span_lo[c][i])) continue;
          a = s; b = e; placed = 1;
        end else begin
          if (i == span_cnt[c]) continue;
          a = span_lo[c][i]; b = span_hi[c][i];
        end
        if (n > 0 && me[n-1] >= a) begin
          if (b > me[n-1]) me[n-1] = b;
        end else if (n <= INTERVALS) begin
          ms[n] = a; me[n] = b; n++;
        end
      end
    end
    if (n > INTERVALS) return;
    for (int i = 0; i < n; i++) begin
      span_lo[c][i] = ms[i];
      span_hi[c][i] = me[i];
    end
    span_cnt[c] = n;
  endfunction

  function automatic verdict_t predict_status(action_e act, key_t k,
      logic [15:0] offw, logic [15:0] len, logic [63:0] now);
    verdict_t v;
    int hit;
    logic [16:0] s, e;
    v = '{ST_PENDING, '0, '0};
    if (act == ACT_FRAG) begin
      hit = -1;
      s = {1'b0, offw & OFFSET_MASK};
      e = s + len;
      for (int c = 0; c < CONTEXTS && hit < 0; c++)
        if (live[c] && keys[c] == k) hit = c;
      if (hit < 0) begin
        for (int c = 0; c < CONTEXTS && hit < 0; c++)
          if (!live[c]) hit = c;
        if (hit < 0) v.status = ST_DROPPED;
        else begin
          release_ctx(hit);
          live[hit] = 1'b1;
          keys[hit] = k;
        end
      end
      if (hit >= 0) begin
        stamp[hit] = now;
        merge_span(hit, s, e);
        if ((offw & MF_BIT_MASK) == 0) begin
          got_last[hit] = 1'b1;
          if (tot_len[hit] < e) tot_len[hit] = e;
        end
        if (got_last[hit] && span_cnt[hit] > 0 && span_lo[hit][0] == 0 &&
            span_hi[hit][0] >= tot_len[hit]) begin
          v.status = ST_COMPLETE;
          v.total = tot_len[hit];
          release_ctx(hit);
        end
      end
    end else if (act == ACT_SWEEP) begin
      for (int c = 0; c < CONTEXTS; c++)
        if (live[c] && (now - stamp[c]) > timeout_q) begin
          release_ctx(c);
          v.expired++;
        end
      v.status = ST_SWEPT;
    end else if (act == ACT_FLUSH) begin
      for (int c = 0; c < CONTEXTS; c++) release_ctx(c);
      v.status = ST_FLUSHED;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    key_t k;
    if (!rst_ni) begin
      timeout_q = TIMEOUT_RESET;
      for (int c = 0; c < CONTEXTS; c++) release_ctx(c);
      awaited.delete();
      errors_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) timeout_q = cfg_i.data;
      // Check the result before queuing a new prediction.
      if (out_i.valid && out_i.ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result status %0d", $time, out_i.status);
          errors_o <= errors_o + 1;
        end else begin
          want = awaited.pop_front();
          if (out_i.status !== want.status || out_i.total_length !== want.total ||
              out_i.expired_count !== want.expired) begin
            $display("%0t: mismatch expected st=%0d len=%0d exp=%0d got st=%0d len=%0d exp=%0d",
                     $time, want.status, want.total, want.expired, out_i.status,
                     out_i.total_length, out_i.expired_count);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        k = '{in_i.src_addr_high, in_i.src_addr_low, in_i.dst_addr_high,
              in_i.dst_addr_low, in_i.fragment_ident, in_i.next_header};
        awaited.push_back(predict_status(action_e'(in_i.action), k, in_i.offset_field,
                                         in_i.fragment_length, in_i.now_time));
      end
    end
  end

endmodule

// ===== tb/tb_ipv6_fragment_reassembly_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv6_fragment_reassembly_tracker
// Drives fragments, sweeps and flushes into the tracker with random gaps and
// result stalls; the scoreboard predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_ipv6_fragment_reassembly_tracker;
  import ifrt_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  bit   hold_rx;
  bit   rx_gaps;

  ifrt_in_if  req_ch ();
  ifrt_out_if res_ch ();
  ifrt_cfg_if cfg_ch ();

  ipv6_fragment_reassembly_tracker uut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (req_ch), .out_o (res_ch), .cfg_i (cfg_ch)
  );

  ifrt_scoreboard chk (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (req_ch), .out_i (res_ch), .cfg_i (cfg_ch),
    .errors_o (errors), .pending_o (pending)
  );

  // A small pool of flow keys so that fragments hit live contexts often.
  key_t flows [48];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard ceiling on run time.
  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall per transaction, long hold when asked.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) res_ch.ready <= 1'b0;
      else if (res_ch.ready && res_ch.valid) res_ch.ready <= 1'b0;
      else if (!res_ch.ready) begin
        if (rx_gaps) repeat ($urandom_range(0, 11)) @(posedge clk_i);
        if (!hold_rx) res_ch.ready <= 1'b1;
      end
    end
  end

  // Keep valid high into the next request when there is no gap.
  task automatic send(action_e act, key_t k, logic [15:0] offw, logic [15:0] len,
                      logic [63:0] now, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.action          <= act;
    req_ch.src_addr_high   <= k.src_high;
    req_ch.src_addr_low    <= k.src_low;
    req_ch.dst_addr_high   <= k.dst_high;
    req_ch.dst_addr_low    <= k.dst_low;
    req_ch.fragment_ident  <= k.ident;
    req_ch.next_header     <= k.proto;
    req_ch.offset_field    <= offw;
    req_ch.fragment_length <= len;
    req_ch.now_time        <= now;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Drain, let the tracker settle, then write the timeout.
  task automatic set_timeout(logic [63:0] val);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (2 * 32 + 4 * 32 + 20) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic key_t rand_key();
    key_t k;
    k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, 8'($urandom)};
    return k;
  endfunction

  initial begin
    logic [63:0] clock_now;
    key_t k;
    int f;
    logic [15:0] off, len;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_FRAG;
    {req_ch.src_addr_high, req_ch.src_addr_low, req_ch.dst_addr_high,
     req_ch.dst_addr_low} = '0;
    req_ch.fragment_ident = '0;
    req_ch.next_header = '0;
    req_ch.offset_field = '0;
    req_ch.fragment_length = '0;
    req_ch.now_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    hold_rx = 0;
    rx_gaps = 1;
    clock_now = 64'd1000;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (flows[i]) flows[i] = rand_key();
    flows[0] = '0;
    flows[1] = '1;

    // Directed: extremes of key and fields, every action, special cases.
    send(ACT_FRAG, flows[0], 16'h0000, 16'd0, 64'd0, 0);          // empty, last -> complete? no
    send(ACT_FRAG, flows[1], 16'hFFF9, 16'hFFFF, '1, 0);         // top offset, max length
    send(ACT_FRAG, flows[1], 16'h0001, 16'd16, '1, 0);
    send(ACT_FRAG, flows[1], 16'h0011, 16'hFFE8, '1, 0);          // touching intervals merge, no last frag
    send(ACT_FRAG, flows[2], 16'h0008, 16'd8, 64'd5, 0);
    send(ACT_FRAG, flows[2], 16'h0000, 16'd8, 64'd6, 0);          // last frag at 0 fills the gap, completes
    send(ACT_FRAG, flows[2], 16'h0011, 16'd8, 64'd7, 0);
    send(ACT_FRAG, flows[2], 16'h0010, 16'd8, 64'd7, 0);          // last frag, gap below 16, not complete
    for (int i = 0; i < 34; i++)                                   // list overflow
      send(ACT_FRAG, flows[3], 16'(i * 32 + 16) | 16'h0001, 16'd8, 64'd9, 0);
    send(ACT_RSVD, flows[3], 16'hFFFF, 16'hFFFF, '1, 0);
    send(ACT_SWEEP, flows[0], '0, '0, 64'd20, 0);
    send(ACT_SWEEP, flows[0], '0, '0, 64'd100000000000, 0);       // wrap of idle test
    for (int i = 0; i < 34; i++)                                   // fill table, then drop
      send(ACT_FRAG, rand_key(), 16'h0009, 16'd8, clock_now, 0);
    send(ACT_FLUSH, flows[0], '0, '0, '0, 0);

    set_timeout('0);
    set_timeout('1);
    set_timeout(64'd500);

    for (int n = 0; n < 2000; n++) begin
      if (n == 600) begin
        // Stall the receiver while requests keep arriving.
        hold_rx = 1;
        fork begin repeat (400) @(posedge clk_i); hold_rx = 0; end join_none
      end
      if (n == 800) begin
        req_ch.valid <= 1'b0;
        wait (pending == 0);
      end
      if (n == 1000) set_timeout('0);
      if (n == 1300) set_timeout(64'd200);
      if (n == 1500) rx_gaps = 0;
      if (n == 1700) rx_gaps = 1;
      clock_now += $urandom_range(0, 40);
      f = $urandom_range(0, 47);
      k = flows[f];
      if ($urandom_range(0, 9) == 0) begin
        flows[f] = rand_key();
        k = flows[f];
      end
      off = 16'($urandom_range(0, 15) * 8);
      len = 16'($urandom_range(0, 3) * 8);
      if ($urandom_range(0, 3) != 0) off |= 16'h0001;
      if ($urandom_range(0, 19) == 0) begin
        off = 16'($urandom);
        len = 16'($urandom);
      end
      case ($urandom_range(0, 39))
        0:       send(ACT_FLUSH, k, off, len, clock_now, 1);
        1, 2, 3: send(ACT_SWEEP, k, off, len, clock_now, 1);
        4:       send(ACT_RSVD, k, off, len, clock_now, 1);
        default: send(ACT_FRAG, k, off, len,
                      ($urandom_range(0, 99) == 0) ? {$urandom, $urandom} : clock_now, 1);
      endcase
    end

    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
